### hdl/grd_pkg.sv
// Shared widths, types, register indexes and reset values for the gyro distance block.
package grd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_W      = 2 * SAMPLE_W;
  localparam int ROOT_W     = SAMPLE_W;
  localparam int RATE_W     = 23;
  localparam int SPEED_W    = 31;
  localparam int DIST_W     = 48;
  localparam int SCALE_W    = 32;
  localparam int SMOOTH_W   = 17;
  localparam int LEG_W      = 8;
  localparam int INTERVAL_W = 20;
  localparam int Q16        = 16;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MAG_LSB    = SCALE_W - FRAC_BITS;
  localparam int LVL_SUM_W  = RATE_W + SMOOTH_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SAMPLE_W-1:0]        abs_t;
  typedef logic [SUM_W-1:0]           sum_t;
  typedef logic [RATE_W-1:0]          rate_t;
  typedef logic [SPEED_W-1:0]         speed_t;
  typedef logic [DIST_W-1:0]          dist_t;
  typedef logic [DIST_W:0]            dist_ext_t;
  typedef logic [SCALE_W-1:0]         scale_t;
  typedef logic [SMOOTH_W-1:0]        smooth_t;
  typedef logic [LEG_W-1:0]           leg_t;
  typedef logic [INTERVAL_W-1:0]      interval_t;
  typedef logic [MUL_W-1:0]           mul_op_t;
  typedef logic [PROD_W-1:0]          prod_t;
  typedef logic [LVL_SUM_W-1:0]       lvl_sum_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  localparam cfg_idx_t CFG_RATE_SCALE  = 2'd0;
  localparam cfg_idx_t CFG_SMOOTHING   = 2'd1;
  localparam cfg_idx_t CFG_LEG_LENGTH  = 2'd2;
  localparam cfg_idx_t CFG_INTERVAL    = 2'd3;

  localparam scale_t    RATE_SCALE_RST = 32'd1311823;
  localparam smooth_t   SMOOTHING_RST  = 17'd6554;
  localparam leg_t      LEG_LENGTH_RST = 8'd50;
  localparam interval_t INTERVAL_RST   = 20'd32768;

  localparam smooth_t   ONE_Q16        = smooth_t'(1) << Q16;
  localparam rate_t     RATE_MAX       = '1;
  localparam dist_t     DIST_MAX       = '1;

endpackage

### hdl/grd_if.sv
// Channel interfaces: configuration writes, gyro samples and distance results.
interface grd_cfg_if;
  logic                 valid;
  logic                 ready;
  grd_pkg::cfg_idx_t    index;
  grd_pkg::cfg_data_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface grd_sample_if;
  logic              valid;
  logic              ready;
  grd_pkg::sample_t  raw_x;
  grd_pkg::sample_t  raw_y;
  grd_pkg::sample_t  raw_z;
  logic              first_sample;
  logic              last_sample;

  modport source (output valid, output raw_x, output raw_y, output raw_z,
                  output first_sample, output last_sample, input ready);
  modport sink   (input valid, input raw_x, input raw_y, input raw_z,
                  input first_sample, input last_sample, output ready);
endinterface

interface grd_result_if;
  logic             valid;
  logic             ready;
  grd_pkg::rate_t   rate_magnitude;
  grd_pkg::rate_t   filtered_rate;
  grd_pkg::speed_t  linear_speed;
  grd_pkg::dist_t   distance;
  logic             run_end;

  modport source (output valid, output rate_magnitude, output filtered_rate,
                  output linear_speed, output distance, output run_end, input ready);
  modport sink   (input valid, input rate_magnitude, input filtered_rate,
                  input linear_speed, input distance, input run_end, output ready);
endinterface

### hdl/gyro_rate_to_distance.sv
// Gyro magnitude, low-pass filter and distance integrator, top level.
//
// Channels: cfg_i takes register writes (index, data) and is always ready.
// sample_i takes one three-axis gyro sample per transaction; result_o gives
// one result per sample: magnitude, filtered rate, speed, distance, run end.
// A small sequencer drives one shared 32x32 multiplier and a bit-pair
// square root stepper. Per sample: squaring and summing of the three
// axes, the square root, the scale, filter and integrate multiplies,
// and a hand-off to the output register; the square root loop dominates.
// sample_i.ready is high only while the sequencer is idle.
// The output register lets the sequencer go back to idle while a result
// waits; if the receiver stalls, the next sample completes its work and
// then holds in the hand-off step until the output register frees up.
// Reset (rst_ni low, async) restores the default register values, clears
// the filter level and the distance, and drops all valids.
// first_sample clears filter and distance before the sample is processed.
module gyro_rate_to_distance (
  input  logic          clk_i,
  input  logic          rst_ni,
  grd_cfg_if.sink       cfg_i,
  grd_sample_if.sink    sample_i,
  grd_result_if.source  result_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQ    = 4'd1;
  localparam logic [3:0] ST_ROOT  = 4'd2;
  localparam logic [3:0] ST_SCALE = 4'd3;
  localparam logic [3:0] ST_MAG   = 4'd4;
  localparam logic [3:0] ST_NEW   = 4'd5;
  localparam logic [3:0] ST_OLD   = 4'd6;
  localparam logic [3:0] ST_LEVEL = 4'd7;
  localparam logic [3:0] ST_LEG   = 4'd8;
  localparam logic [3:0] ST_INT   = 4'd9;
  localparam logic [3:0] ST_DIST  = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_LAST = 2'd3;

  localparam grd_pkg::sum_t ROOT_BIT_INIT = grd_pkg::sum_t'(1) << (grd_pkg::SUM_W - 2);

  // control and state registers
  logic [3:0]          state_q, state_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  grd_pkg::scale_t     rate_scale_q;
  grd_pkg::smooth_t    smoothing_q;
  grd_pkg::leg_t       leg_q;
  grd_pkg::interval_t  interval_q;
  grd_pkg::rate_t      level_q, level_d;
  grd_pkg::dist_t      dist_q, dist_d;

  // datapath registers
  grd_pkg::abs_t       ax_q, ay_q, az_q, ax_d, ay_d, az_d;
  logic                last_q, last_d;
  grd_pkg::sum_t       rem_q, rem_d;
  grd_pkg::sum_t       root_q, root_d;
  grd_pkg::sum_t       bit_q, bit_d;
  grd_pkg::prod_t      prod_q;
  grd_pkg::lvl_sum_t   acc_q, acc_d;
  grd_pkg::rate_t      mag_q, mag_d;
  grd_pkg::speed_t     speed_q, speed_d;

  grd_pkg::rate_t      out_mag_q, out_level_q;
  grd_pkg::speed_t     out_speed_q;
  grd_pkg::dist_t      out_dist_q;
  logic                out_run_end_q;
  logic                out_load;

  logic                in_acc, cfg_acc;
  grd_pkg::mul_op_t    mul_a, mul_b;
  grd_pkg::prod_t      mul_p;
  grd_pkg::smooth_t    w, w_inv;
  grd_pkg::abs_t       sq_op;
  grd_pkg::sum_t       trial;
  grd_pkg::lvl_sum_t   lvl_sum;
  grd_pkg::dist_ext_t  dist_sum;

  function automatic grd_pkg::abs_t abs_val(grd_pkg::sample_t v);
    grd_pkg::abs_t u;
    u = grd_pkg::abs_t'(v);
    return v[grd_pkg::SAMPLE_W-1] ? (~u + grd_pkg::abs_t'(1)) : u;
  endfunction

  assign cfg_i.ready    = 1'b1;
  assign cfg_acc        = cfg_i.valid;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_acc         = sample_i.valid && (state_q == ST_IDLE);

  assign w     = (smoothing_q > grd_pkg::ONE_Q16) ? grd_pkg::ONE_Q16 : smoothing_q;
  assign w_inv = grd_pkg::ONE_Q16 - w;

  always_comb begin
    case (cnt_q)
      AXIS_X:  sq_op = ax_q;
      AXIS_Y:  sq_op = ay_q;
      AXIS_Z:  sq_op = az_q;
      default: sq_op = '0;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = grd_pkg::mul_op_t'(sq_op);
        mul_b = grd_pkg::mul_op_t'(sq_op);
      end
      ST_SCALE: begin
        mul_a = grd_pkg::mul_op_t'(root_q[grd_pkg::ROOT_W-1:0]);
        mul_b = grd_pkg::mul_op_t'(rate_scale_q);
      end
      ST_NEW: begin
        mul_a = grd_pkg::mul_op_t'(mag_q);
        mul_b = grd_pkg::mul_op_t'(w);
      end
      ST_OLD: begin
        mul_a = grd_pkg::mul_op_t'(level_q);
        mul_b = grd_pkg::mul_op_t'(w_inv);
      end
      ST_LEG: begin
        mul_a = grd_pkg::mul_op_t'(level_q);
        mul_b = grd_pkg::mul_op_t'(leg_q);
      end
      ST_INT: begin
        mul_a = grd_pkg::mul_op_t'(prod_q[grd_pkg::SPEED_W-1:0]);
        mul_b = grd_pkg::mul_op_t'(interval_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = grd_pkg::prod_t'(mul_a) * grd_pkg::prod_t'(mul_b);
  assign trial    = root_q + bit_q;
  assign lvl_sum  = acc_q + prod_q[grd_pkg::LVL_SUM_W-1:0];
  assign dist_sum = grd_pkg::dist_ext_t'(dist_q)
                  + grd_pkg::dist_ext_t'(prod_q[grd_pkg::PROD_W-1:grd_pkg::Q16]);
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    level_d     = level_q;
    dist_d      = dist_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    az_d        = az_q;
    last_d      = last_q;
    rem_d       = rem_q;
    root_d      = root_q;
    bit_d       = bit_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    speed_d     = speed_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ax_d    = abs_val(sample_i.raw_x);
          ay_d    = abs_val(sample_i.raw_y);
          az_d    = abs_val(sample_i.raw_z);
          last_d  = sample_i.last_sample;
          rem_d   = '0;
          root_d  = '0;
          bit_d   = ROOT_BIT_INIT;
          cnt_d   = AXIS_X;
          state_d = ST_SQ;
          if (sample_i.first_sample) begin
            level_d = '0;
            dist_d  = '0;
          end
        end
      end
      ST_SQ: begin
        // prod_q holds the square issued in the previous cycle
        rem_d = rem_q + prod_q[grd_pkg::SUM_W-1:0];
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == AXIS_LAST) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q[0]) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_MAG;
      ST_MAG: begin
        if (prod_q[grd_pkg::PROD_W-1:grd_pkg::MAG_LSB+grd_pkg::RATE_W] != '0) begin
          mag_d = grd_pkg::RATE_MAX;
        end else begin
          mag_d = prod_q[grd_pkg::MAG_LSB +: grd_pkg::RATE_W];
        end
        state_d = ST_NEW;
      end
      ST_NEW: state_d = ST_OLD;
      ST_OLD: begin
        acc_d   = prod_q[grd_pkg::LVL_SUM_W-1:0];
        state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        level_d = lvl_sum[grd_pkg::Q16 +: grd_pkg::RATE_W];
        state_d = ST_LEG;
      end
      ST_LEG: state_d = ST_INT;
      ST_INT: begin
        speed_d = prod_q[grd_pkg::SPEED_W-1:0];
        state_d = ST_DIST;
      end
      ST_DIST: begin
        dist_d  = dist_sum[grd_pkg::DIST_W] ? grd_pkg::DIST_MAX
                                             : dist_sum[grd_pkg::DIST_W-1:0];
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= AXIS_X;
      out_valid_q  <= 1'b0;
      level_q      <= '0;
      dist_q       <= '0;
      rate_scale_q <= grd_pkg::RATE_SCALE_RST;
      smoothing_q  <= grd_pkg::SMOOTHING_RST;
      leg_q        <= grd_pkg::LEG_LENGTH_RST;
      interval_q   <= grd_pkg::INTERVAL_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      level_q     <= level_d;
      dist_q      <= dist_d;
      if (cfg_acc) begin
        case (cfg_i.index)
          grd_pkg::CFG_RATE_SCALE: rate_scale_q <= cfg_i.data[grd_pkg::SCALE_W-1:0];
          grd_pkg::CFG_SMOOTHING:  smoothing_q  <= cfg_i.data[grd_pkg::SMOOTH_W-1:0];
          grd_pkg::CFG_LEG_LENGTH: leg_q        <= cfg_i.data[grd_pkg::LEG_W-1:0];
          grd_pkg::CFG_INTERVAL:   interval_q   <= cfg_i.data[grd_pkg::INTERVAL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    az_q    <= az_d;
    last_q  <= last_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    bit_q   <= bit_d;
    prod_q  <= mul_p;
    acc_q   <= acc_d;
    mag_q   <= mag_d;
    speed_q <= speed_d;
    if (out_load) begin
      out_mag_q     <= mag_q;
      out_level_q   <= level_q;
      out_speed_q   <= speed_q;
      out_dist_q    <= dist_q;
      out_run_end_q <= last_q;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.rate_magnitude = out_mag_q;
  assign result_o.filtered_rate  = out_level_q;
  assign result_o.linear_speed   = out_speed_q;
  assign result_o.distance       = out_dist_q;
  assign result_o.run_end        = out_run_end_q;

endmodule

### hdl/grd_checker.sv
// Port-level checks for the gyro distance block, bound to its top level.
module grd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_ready_i,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input grd_pkg::rate_t   out_mag_i,
  input grd_pkg::rate_t   out_level_i,
  input grd_pkg::speed_t  out_speed_i,
  input grd_pkg::dist_t   out_dist_i,
  input logic             out_run_end_i
);

  // a sample keeps the sequencer busy, so ready drops right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i ##1 !in_ready_i)
    else $error("sample channel ready right after a transaction");

  // a result is never produced in the cycle right after a sample is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result appeared one cycle after sample transaction");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel not ready");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_mag_i)
      && $stable(out_level_i) && $stable(out_speed_i) && $stable(out_dist_i)
      && $stable(out_run_end_i))
    else $error("stalled result changed");

endmodule

bind gyro_rate_to_distance grd_checker u_grd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_i  (cfg_i.ready),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_mag_i    (result_o.rate_magnitude),
  .out_level_i  (result_o.filtered_rate),
  .out_speed_i  (result_o.linear_speed),
  .out_dist_i   (result_o.distance),
  .out_run_end_i(result_o.run_end)
);
